[hw/rtl/kefs_pkg.sv]
package kefs_pkg;

   localparam int DATA_WIDTH = 48;
   localparam int FRAC_BITS = 24;
   localparam int COEF_WIDTH = 28;
   localparam int VOL_WIDTH = DATA_WIDTH - 1;
   localparam int CSR_WIDTH = DATA_WIDTH - 1;
   localparam int CSR_INDEX_WIDTH = 2;

   // fixed latencies of the arithmetic units
   localparam int MUL_LAT = 4;
   localparam int DIV_LAT = DATA_WIDTH + 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_ONE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_TWO = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_K_FLOOR = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOW_RE_MODE = 2'd3;

   localparam logic [COEF_WIDTH-1:0] COEF_ONE_RESET = 28'd24159191;
   localparam logic [COEF_WIDTH-1:0] COEF_TWO_RESET = 28'd32212255;
   localparam logic [CSR_WIDTH-1:0] K_FLOOR_RESET = CSR_WIDTH'(1);

   typedef logic signed [DATA_WIDTH-1:0] data_type;

   localparam data_type DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam data_type DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] production;
      logic signed [DATA_WIDTH-1:0] kinetic_energy;
      logic signed [DATA_WIDTH-1:0] dissipation;
      logic [VOL_WIDTH-1:0]         dual_volume;
      logic signed [DATA_WIDTH-1:0] damp_d;
      logic signed [DATA_WIDTH-1:0] damp_e;
      logic signed [DATA_WIDTH-1:0] damp_f1;
      logic signed [DATA_WIDTH-1:0] damp_f2;
      logic signed [DATA_WIDTH-1:0] resid_k_in;
      logic signed [DATA_WIDTH-1:0] resid_eps_in;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] resid_k_out;
      logic signed [DATA_WIDTH-1:0] resid_eps_out;
      logic                         eps_applied;
      logic                         saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         sat;
   } clip_type;

   function automatic clip_type clip_sum(logic [DATA_WIDTH:0] s);
      clip_type r;
      r.sat = s[DATA_WIDTH] != s[DATA_WIDTH-1];
      if (r.sat) begin
         r.value = s[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
      end else begin
         r.value = s[DATA_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic clip_type sat_add(data_type a, data_type b);
      logic [DATA_WIDTH:0] s;
      s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
      return clip_sum(s);
   endfunction

   function automatic clip_type sat_sub(data_type a, data_type b);
      logic [DATA_WIDTH:0] s;
      s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
      return clip_sum(s);
   endfunction

endpackage

[hw/rtl/kefs_mul.sv]
module kefs_mul (
   input  logic               clock,
   input  logic               en,
   input  kefs_pkg::data_type a,
   input  kefs_pkg::data_type b,
   output kefs_pkg::data_type p,
   output logic               sat
);
   import kefs_pkg::*;

   localparam int DW = DATA_WIDTH;
   localparam int HALF = (DW + 1) / 2;
   localparam int HI = DW - HALF;
   localparam int PW = 2 * DW;

   logic [DW-1:0] ua;
   logic [DW-1:0] ub;
   logic [DW-1:0] mag_a_ff;
   logic [DW-1:0] mag_b_ff;
   logic          neg1_ff;

   logic [2*HALF-1:0] ll_ff;
   logic [DW-1:0]     lh_ff;
   logic [DW-1:0]     hl_ff;
   logic [2*HI-1:0]   hh_ff;
   logic              neg2_ff;

   logic [PW-1:0] prod_in;
   logic [PW-1:0] prod_ff;
   logic          neg3_ff;

   logic signed [PW-1:0] sprod;
   logic signed [PW-1:0] shf;
   logic [PW-DW:0]       top_bits;
   logic                 in_range;
   data_type             p_ff;
   logic                 sat_ff;

   assign ua = a;
   assign ub = b;

   // magnitude partial products, sum, then sign, floor shift and clip
   assign prod_in = PW'(ll_ff) + (PW'(lh_ff) << HALF) + (PW'(hl_ff) << HALF)
                  + (PW'(hh_ff) << (2 * HALF));

   always_comb begin
      sprod = neg3_ff ? $signed(~prod_ff + 1'b1) : $signed(prod_ff);
      shf = sprod >>> FRAC_BITS;
      top_bits = shf[PW-1:DW-1];
      in_range = (&top_bits) | ~(|top_bits);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_a_ff <= ua[DW-1] ? ~ua + 1'b1 : ua;
         mag_b_ff <= ub[DW-1] ? ~ub + 1'b1 : ub;
         neg1_ff <= ua[DW-1] ^ ub[DW-1];

         ll_ff <= mag_a_ff[HALF-1:0] * mag_b_ff[HALF-1:0];
         lh_ff <= mag_a_ff[HALF-1:0] * mag_b_ff[DW-1:HALF];
         hl_ff <= mag_a_ff[DW-1:HALF] * mag_b_ff[HALF-1:0];
         hh_ff <= mag_a_ff[DW-1:HALF] * mag_b_ff[DW-1:HALF];
         neg2_ff <= neg1_ff;

         prod_ff <= prod_in;
         neg3_ff <= neg2_ff;

         if (in_range) begin
            p_ff <= shf[DW-1:0];
         end else begin
            p_ff <= shf[PW-1] ? DATA_MIN : DATA_MAX;
         end
         sat_ff <= ~in_range;
      end
   end

   assign p = p_ff;
   assign sat = sat_ff;

endmodule

[hw/rtl/kefs_div.sv]
module kefs_div (
   input  logic                            clock,
   input  logic                            en,
   input  kefs_pkg::data_type              num,
   input  logic [kefs_pkg::VOL_WIDTH-1:0]  den,
   output kefs_pkg::data_type              quo,
   output logic                            sat
);
   import kefs_pkg::*;

   localparam int DW = DATA_WIDTH;
   localparam int FB = FRAC_BITS;
   localparam int RW = DW - 1;
   localparam int NSTEP = DW;

   logic [DW-1:0] unum;
   logic [DW-1:0] mag1_ff;
   logic          neg1_ff;
   logic          zero1_ff;
   logic [RW-1:0] den1_ff;

   logic [RW-1:0] rem_ff [0:NSTEP];
   logic [DW-1:0] low_ff [0:NSTEP];
   logic [DW-1:0] q_ff [0:NSTEP];
   logic [RW-1:0] den_ff [0:NSTEP];
   logic [NSTEP:0] neg_ff;
   logic [NSTEP:0] zero_ff;
   logic [NSTEP:0] ovf_ff;

   logic [DW-1:0] trial [0:NSTEP-1];
   logic [DW-1:0] diff [0:NSTEP-1];
   logic [NSTEP-1:0] ge;

   logic [RW-1:0] top_ext;
   logic [DW-1:0] qf;
   data_type      quo_ff;
   logic          sat_ff;

   assign unum = num;
   // dividend is magnitude shifted left by the fraction bits; its top part decides overflow
   assign top_ext = RW'(mag1_ff[DW-1:DW-FB]);
   assign qf = q_ff[NSTEP];

   always_comb begin
      for (int j = 0; j < NSTEP; j++) begin
         trial[j] = {rem_ff[j], low_ff[j][DW-1]};
         diff[j] = trial[j] - {1'b0, den_ff[j]};
         ge[j] = trial[j] >= {1'b0, den_ff[j]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag1_ff <= unum[DW-1] ? ~unum + 1'b1 : unum;
         neg1_ff <= unum[DW-1];
         zero1_ff <= ~(|unum);
         den1_ff <= den;

         rem_ff[0] <= top_ext;
         low_ff[0] <= {mag1_ff[DW-FB-1:0], {FB{1'b0}}};
         q_ff[0] <= '0;
         den_ff[0] <= den1_ff;
         neg_ff[0] <= neg1_ff;
         zero_ff[0] <= zero1_ff;
         ovf_ff[0] <= top_ext >= den1_ff;

         // one restoring step per stage
         for (int j = 0; j < NSTEP; j++) begin
            rem_ff[j+1] <= ge[j] ? diff[j][RW-1:0] : trial[j][RW-1:0];
            low_ff[j+1] <= {low_ff[j][DW-2:0], 1'b0};
            q_ff[j+1] <= {q_ff[j][DW-2:0], ge[j]};
            den_ff[j+1] <= den_ff[j];
            neg_ff[j+1] <= neg_ff[j];
            zero_ff[j+1] <= zero_ff[j];
            ovf_ff[j+1] <= ovf_ff[j];
         end

         priority if (zero_ff[NSTEP]) begin
            quo_ff <= '0;
            sat_ff <= 1'b0;
         end else if (ovf_ff[NSTEP]) begin
            quo_ff <= neg_ff[NSTEP] ? DATA_MIN : DATA_MAX;
            sat_ff <= 1'b1;
         end else if (!neg_ff[NSTEP]) begin
            quo_ff <= qf[DW-1] ? DATA_MAX : qf;
            sat_ff <= qf[DW-1];
         end else if (qf > {1'b1, {(DW-1){1'b0}}}) begin
            quo_ff <= DATA_MIN;
            sat_ff <= 1'b1;
         end else begin
            quo_ff <= ~qf + 1'b1;
            sat_ff <= 1'b0;
         end
      end
   end

   assign quo = quo_ff;
   assign sat = sat_ff;

endmodule

[hw/rtl/k_eps_face_source_term.sv]
// k-epsilon source term per mesh face: one transaction accepted per cycle while req_ready
// is high; every transaction gives one result transaction after passing four 4-stage
// multipliers in series, a DATA_WIDTH + 3 stage restoring divider for d * eps / k, and
// the saturating add stages. The pipeline advances as a whole while the output register
// is empty or being taken; when rsp_ready is low with a result waiting, the whole
// pipeline holds and req_ready drops in the same cycle. Configuration is written through
// the csr_ port while no transaction is in flight: the user must keep to this, the block
// does not enforce it.
module k_eps_face_source_term (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  kefs_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output kefs_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [kefs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [kefs_pkg::CSR_WIDTH-1:0]       csr_wdata
);
   import kefs_pkg::*;

   localparam int DW = DATA_WIDTH;

   // stage numbers; a unit launched from stage s delivers alongside stage s + latency
   localparam int ST_T1 = 1;
   localparam int ST_T2 = 2;
   localparam int ST_KM = ST_T2 + MUL_LAT;
   localparam int ST_RK = ST_KM + 1;
   localparam int ST_M1 = MUL_LAT;
   localparam int ST_AB = ST_M1 + 1;
   localparam int ST_M2 = ST_M1 + MUL_LAT;
   localparam int ST_D = ST_M2 + 1;
   localparam int ST_N = ST_D + MUL_LAT;
   localparam int ST_Q = ST_N + DIV_LAT;
   localparam int ST_QE = ST_Q + 1;
   localparam int ST_G = ST_QE + MUL_LAT;
   localparam int ST_OUT = ST_G + 1;

   typedef struct packed {
      data_type             eps;
      data_type             k;
      logic [VOL_WIDTH-1:0] vol;
      data_type             dd;
      data_type             e;
      data_type             f1;
      data_type             f2;
      data_type             rk;
      data_type             re;
      data_type             t;
      data_type             a;
      data_type             b;
      data_type             d;
      data_type             q;
      logic                 applied;
      logic                 kflag;
      logic                 eflag;
   } side_type;

   logic [COEF_WIDTH-1:0] coef_one_ff;
   logic [COEF_WIDTH-1:0] coef_two_ff;
   logic [CSR_WIDTH-1:0]  k_floor_ff;
   logic                  low_re_ff;

   logic           adv;
   logic [ST_OUT:1] vld_ff;
   side_type       side_ff [1:ST_G];
   side_type       side_in [1:ST_G];
   rsp_type        rsp_data_ff;
   rsp_type        rsp_data_in;

   data_type m_a1_p, m_b1_p, m_a2_p, m_b2_p, m_k_p, m_n_p, m_g_p, div_q;
   logic     m_a1_sat, m_b1_sat, m_a2_sat, m_b2_sat, m_k_sat, m_n_sat, m_g_sat, div_sat;
   data_type a2;
   data_type b2;

   clip_type t1_c, t2_c, rk_c, d_c, qe_c, g_c;
   logic     applied_in;

   assign adv = ~vld_ff[ST_OUT] | rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[ST_OUT];
   assign rsp_data = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_one_ff <= COEF_ONE_RESET;
         coef_two_ff <= COEF_TWO_RESET;
         k_floor_ff <= K_FLOOR_RESET;
         low_re_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_COEF_ONE: coef_one_ff <= csr_wdata[COEF_WIDTH-1:0];
            CSR_COEF_TWO: coef_two_ff <= csr_wdata[COEF_WIDTH-1:0];
            CSR_K_FLOOR: k_floor_ff <= csr_wdata;
            CSR_LOW_RE_MODE: low_re_ff <= csr_wdata[0];
         endcase
      end
   end

   // eps source only for non-negative k at or above the floor
   assign applied_in = ~req_data.kinetic_energy[DW-1]
                     & (req_data.kinetic_energy[DW-2:0] >= k_floor_ff);

   assign t1_c = sat_sub(req_data.production, req_data.dissipation);
   assign t2_c = sat_sub(side_ff[ST_T2-1].t, side_ff[ST_T2-1].dd);
   assign rk_c = sat_add(side_ff[ST_KM].rk, m_k_p);
   assign a2 = low_re_ff ? m_a2_p : side_ff[ST_M2].a;
   assign b2 = low_re_ff ? m_b2_p : side_ff[ST_M2].b;
   assign d_c = sat_sub(a2, b2);
   assign qe_c = sat_add(div_q, side_ff[ST_Q].e);
   assign g_c = sat_add(side_ff[ST_G].re, m_g_p);

   kefs_mul u_mul_a1 (
      .clock(clock), .en(adv),
      .a(DW'(coef_one_ff)), .b(req_data.production),
      .p(m_a1_p), .sat(m_a1_sat)
   );

   kefs_mul u_mul_b1 (
      .clock(clock), .en(adv),
      .a(DW'(coef_two_ff)), .b(req_data.dissipation),
      .p(m_b1_p), .sat(m_b1_sat)
   );

   kefs_mul u_mul_a2 (
      .clock(clock), .en(adv),
      .a(m_a1_p), .b(side_ff[ST_M1].f1),
      .p(m_a2_p), .sat(m_a2_sat)
   );

   kefs_mul u_mul_b2 (
      .clock(clock), .en(adv),
      .a(m_b1_p), .b(side_ff[ST_M1].f2),
      .p(m_b2_p), .sat(m_b2_sat)
   );

   kefs_mul u_mul_k (
      .clock(clock), .en(adv),
      .a(side_ff[ST_T2].t), .b(DW'(side_ff[ST_T2].vol)),
      .p(m_k_p), .sat(m_k_sat)
   );

   kefs_mul u_mul_n (
      .clock(clock), .en(adv),
      .a(side_ff[ST_D].d), .b(side_ff[ST_D].eps),
      .p(m_n_p), .sat(m_n_sat)
   );

   kefs_div u_div (
      .clock(clock), .en(adv),
      .num(m_n_p), .den(side_ff[ST_N].k[DW-2:0]),
      .quo(div_q), .sat(div_sat)
   );

   kefs_mul u_mul_g (
      .clock(clock), .en(adv),
      .a(side_ff[ST_QE].q), .b(DW'(side_ff[ST_QE].vol)),
      .p(m_g_p), .sat(m_g_sat)
   );

   always_comb begin
      side_in[ST_T1] = '0;
      side_in[ST_T1].eps = req_data.dissipation;
      side_in[ST_T1].k = req_data.kinetic_energy;
      side_in[ST_T1].vol = req_data.dual_volume;
      side_in[ST_T1].dd = req_data.damp_d;
      side_in[ST_T1].e = req_data.damp_e;
      side_in[ST_T1].f1 = req_data.damp_f1;
      side_in[ST_T1].f2 = req_data.damp_f2;
      side_in[ST_T1].rk = req_data.resid_k_in;
      side_in[ST_T1].re = req_data.resid_eps_in;
      side_in[ST_T1].t = t1_c.value;
      side_in[ST_T1].applied = applied_in;
      side_in[ST_T1].kflag = t1_c.sat;
      for (int s = ST_T1 + 1; s <= ST_G; s++) begin
         side_in[s] = side_ff[s-1];
      end

      // k path
      if (low_re_ff) begin
         side_in[ST_T2].t = t2_c.value;
         side_in[ST_T2].kflag = side_ff[ST_T2-1].kflag | t2_c.sat;
      end
      side_in[ST_RK].rk = rk_c.value;
      side_in[ST_RK].kflag = side_ff[ST_KM].kflag | m_k_sat | rk_c.sat;

      // eps path
      side_in[ST_AB].a = m_a1_p;
      side_in[ST_AB].b = m_b1_p;
      side_in[ST_AB].eflag = m_a1_sat | m_b1_sat;
      side_in[ST_D].d = d_c.value;
      side_in[ST_D].eflag = side_ff[ST_M2].eflag | d_c.sat
                          | (low_re_ff & (m_a2_sat | m_b2_sat));
      side_in[ST_N+1].eflag = side_ff[ST_N].eflag | m_n_sat;
      side_in[ST_QE].q = low_re_ff ? qe_c.value : div_q;
      side_in[ST_QE].eflag = side_ff[ST_Q].eflag | div_sat | (low_re_ff & qe_c.sat);
   end

   always_comb begin
      rsp_data_in.resid_k_out = side_ff[ST_G].rk;
      rsp_data_in.eps_applied = side_ff[ST_G].applied;
      rsp_data_in.resid_eps_out = side_ff[ST_G].applied ? g_c.value : side_ff[ST_G].re;
      rsp_data_in.saturated = side_ff[ST_G].kflag
                            | (side_ff[ST_G].applied
                               & (side_ff[ST_G].eflag | m_g_sat | g_c.sat));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[ST_OUT-1:1], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = ST_T1; s <= ST_G; s++) begin
            side_ff[s] <= side_in[s];
         end
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
